FILE: rtl/core/nfba_pkg.sv
// ----------------------------------------------------------------------------
// nfba_pkg
// Types and constants shared by the next-fit block allocator modules.
// ----------------------------------------------------------------------------
package nfba_pkg;

	localparam int MAX_BLOCKS_DEF   = 64;
	localparam int HEADER_BYTES_DEF = 16;
	localparam int POOL_BYTES_DEF   = 65535;

	localparam logic [1:0] REQ_INIT  = 2'd0;
	localparam logic [1:0] REQ_ALLOC = 2'd1;
	localparam logic [1:0] REQ_FREE  = 2'd2;
	localparam logic [1:0] REQ_NOP   = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NOFIT   = 3'd1;
	localparam logic [2:0] ST_NULL    = 3'd2;
	localparam logic [2:0] ST_UNKNOWN = 3'd3;
	localparam logic [2:0] ST_SMALL   = 3'd4;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] request_size;
		logic [31:0] free_address;
	} req_t;

	typedef struct packed {
		logic [31:0] grant_address;
		logic [2:0]  status;
	} rsp_t;

	// Datapath operations commanded by the controller.
	localparam logic [3:0] OP_NONE    = 4'd0;
	localparam logic [3:0] OP_INIT    = 4'd1;
	localparam logic [3:0] OP_RD      = 4'd2;  // read entry at idx
	localparam logic [3:0] OP_SHUP    = 4'd3;  // entry idx+1 <= entry idx
	localparam logic [3:0] OP_SPLIT   = 4'd4;  // write split remainder at idx+1
	localparam logic [3:0] OP_MARK    = 4'd5;  // set used at idx
	localparam logic [3:0] OP_CLR     = 4'd6;  // clear used at idx
	localparam logic [3:0] OP_GROW    = 4'd7;  // length[idx] += held len + header
	localparam logic [3:0] OP_SHDN    = 4'd8;  // entry idx <= held entry (from idx+1)

	typedef struct packed {
		logic [3:0]  op;
		logic [15:0] size;
	} cmd_t;

	typedef struct packed {
		logic [15:0] offset;
		logic [15:0] length;
		logic        used;
	} entry_t;

endpackage

FILE: rtl/core/nfba_datapath.sv
// ----------------------------------------------------------------------------
// nfba_datapath
// Block table memory with one read port and one write port, plus the
// arithmetic for splitting and merging entries.
// ----------------------------------------------------------------------------
module nfba_datapath #(
	parameter int MAX_BLOCKS   = nfba_pkg::MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = nfba_pkg::HEADER_BYTES_DEF,
	localparam int IW = $clog2(MAX_BLOCKS)
) (
	input  logic             clk,
	input  nfba_pkg::cmd_t   cmd,
	input  logic [IW-1:0]    idx,
	output nfba_pkg::entry_t rd_entry
);

	localparam logic [15:0] HDR = 16'(HEADER_BYTES);

	nfba_pkg::entry_t mem_q [MAX_BLOCKS];
	nfba_pkg::entry_t rd_q;
	logic             we;
	logic [IW-1:0]    wa;
	nfba_pkg::entry_t wd;
	logic [IW-1:0]    ra;

	// Split writes two entries: the remainder first, the granted block next.
	always_comb begin
		we = 1'b0;
		wa = idx;
		wd = rd_q;
		ra = idx;
		case (cmd.op)
			nfba_pkg::OP_INIT: begin
				we = 1'b1;
				wa = '0;
				wd = '{offset: 16'd0, length: cmd.size - HDR, used: 1'b0};
			end
			nfba_pkg::OP_SHUP: begin
				we = 1'b1;
				wa = idx + IW'(1);
				wd = rd_q;
			end
			nfba_pkg::OP_SPLIT: begin
				we = 1'b1;
				wa = idx + IW'(1);
				wd = '{offset: rd_q.offset + HDR + cmd.size,
					length: rd_q.length - cmd.size - HDR, used: 1'b0};
			end
			nfba_pkg::OP_MARK: begin
				we = 1'b1;
				wd = '{offset: rd_q.offset, length: cmd.size, used: 1'b1};
			end
			nfba_pkg::OP_CLR: begin
				we = 1'b1;
				wd = '{offset: rd_q.offset, length: rd_q.length, used: 1'b0};
			end
			nfba_pkg::OP_GROW: begin
				we = 1'b1;
				wd = '{offset: rd_q.offset, length: rd_q.length + cmd.size + HDR,
					used: rd_q.used};
			end
			nfba_pkg::OP_SHDN: begin
				we = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		if (cmd.op == nfba_pkg::OP_RD) begin
			rd_q <= mem_q[ra];
		end
	end

	assign rd_entry = rd_q;

endmodule

FILE: rtl/core/nfba_ctrl.sv
// ----------------------------------------------------------------------------
// nfba_ctrl
// Sequencer for init, allocate and free: scans the table one entry at a
// time and steps the datapath through shifts, splits and merges.
// ----------------------------------------------------------------------------
module nfba_ctrl #(
	parameter int MAX_BLOCKS   = nfba_pkg::MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = nfba_pkg::HEADER_BYTES_DEF,
	parameter int POOL_BYTES   = nfba_pkg::POOL_BYTES_DEF,
	localparam int IW = $clog2(MAX_BLOCKS),
	localparam int CW = $clog2(MAX_BLOCKS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  nfba_pkg::req_t   in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output nfba_pkg::rsp_t   out_data,
	input  logic [31:0]      pool_base,
	output nfba_pkg::cmd_t   cmd,
	output logic [IW-1:0]    idx,
	input  nfba_pkg::entry_t rd_entry
);

	localparam logic [15:0] HDR = 16'(HEADER_BYTES);
	localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

	localparam logic [4:0] S_BOOT   = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_ARD    = 5'd2;
	localparam logic [4:0] S_ACHK   = 5'd3;
	localparam logic [4:0] S_SHRD   = 5'd4;
	localparam logic [4:0] S_SHWR   = 5'd5;
	localparam logic [4:0] S_SPRD   = 5'd6;
	localparam logic [4:0] S_SPWR   = 5'd7;
	localparam logic [4:0] S_MARK   = 5'd8;
	localparam logic [4:0] S_FRD    = 5'd9;
	localparam logic [4:0] S_FCHK   = 5'd10;
	localparam logic [4:0] S_CLR    = 5'd11;
	localparam logic [4:0] S_NBRD   = 5'd12;
	localparam logic [4:0] S_NBCHK  = 5'd13;
	localparam logic [4:0] S_FLDRD  = 5'd14; // read entry k (to fold)
	localparam logic [4:0] S_FLDLEN = 5'd15; // read entry k-1
	localparam logic [4:0] S_FLDGRW = 5'd16;
	localparam logic [4:0] S_FLDSRD = 5'd17; // read j+1
	localparam logic [4:0] S_FLDSWR = 5'd18; // write j
	localparam logic [4:0] S_FLDEND = 5'd19;
	localparam logic [4:0] S_DONE   = 5'd20;

	logic [4:0]     state_q;
	logic [CW-1:0]  count_q;
	logic [IW-1:0]  rover_q;
	logic [CW-1:0]  i_q;      // scan or fold position
	logic [CW-1:0]  j_q;      // shift position
	logic [IW-1:0]  hit_q;    // granted or freed entry
	logic [15:0]    size_q;
	logic [31:0]    addr_q;
	logic [15:0]    len_q;    // length of folded entry
	logic           split_q;
	logic           rov_used_q;
	logic           fold2_q;  // second (upper) fold under way
	logic           valid_q;
	nfba_pkg::rsp_t rsp_q;
	logic [31:0]    pay;

	assign pay = pool_base + 32'(rd_entry.offset) + 32'(HDR);
	assign in_stall  = (state_q != S_IDLE) || valid_q;
	assign out_valid = valid_q;
	assign out_data  = rsp_q;

	always_comb begin
		cmd = '{op: nfba_pkg::OP_NONE, size: size_q};
		idx = i_q[IW-1:0];
		case (state_q)
			S_BOOT:   cmd.op = nfba_pkg::OP_INIT;
			S_ARD, S_FRD, S_NBRD, S_FLDRD: cmd.op = nfba_pkg::OP_RD;
			S_SHRD:   begin cmd.op = nfba_pkg::OP_RD; idx = IW'(j_q - CW'(1)); end
			S_SHWR:   begin cmd.op = nfba_pkg::OP_SHUP; idx = IW'(j_q - CW'(1)); end
			S_SPRD:   begin cmd.op = nfba_pkg::OP_RD; idx = hit_q; end
			S_SPWR:   begin cmd.op = nfba_pkg::OP_SPLIT; idx = hit_q; end
			S_MARK:   begin
				cmd.op = nfba_pkg::OP_MARK; idx = hit_q;
				cmd.size = split_q ? size_q : rd_entry.length;
			end
			S_CLR:    begin cmd.op = nfba_pkg::OP_CLR; idx = hit_q; end
			S_FLDLEN: begin cmd.op = nfba_pkg::OP_RD; idx = IW'(i_q - CW'(1)); end
			S_FLDGRW: begin
				cmd.op = nfba_pkg::OP_GROW; cmd.size = len_q;
				idx = IW'(i_q - CW'(1));
			end
			S_FLDSRD: begin cmd.op = nfba_pkg::OP_RD; idx = IW'(j_q + CW'(1)); end
			S_FLDSWR: begin cmd.op = nfba_pkg::OP_SHDN; idx = j_q[IW-1:0]; end
			default:  cmd.op = nfba_pkg::OP_NONE;
		endcase
		if (state_q == S_BOOT) begin
			cmd.size = 16'(POOL_BYTES);
		end
		if (state_q == S_IDLE && in_valid && !valid_q
				&& in_data.req_type == nfba_pkg::REQ_INIT
				&& in_data.request_size >= HDR) begin
			cmd.op = nfba_pkg::OP_INIT;
			cmd.size = in_data.request_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_BOOT;
			count_q <= CW'(1);
			rover_q <= '0;
			valid_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			hit_q <= '0;
			size_q <= '0;
			addr_q <= '0;
			len_q <= '0;
			split_q <= 1'b0;
			rov_used_q <= 1'b0;
			fold2_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			if (valid_q && !out_stall) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				S_BOOT: state_q <= S_IDLE;
				S_IDLE: begin
					if (in_valid && !valid_q) begin
						size_q <= in_data.request_size;
						addr_q <= in_data.free_address;
						rsp_q <= '{grant_address: 32'd0, status: nfba_pkg::ST_OK};
						case (in_data.req_type)
							nfba_pkg::REQ_INIT: begin
								if (in_data.request_size < HDR) begin
									rsp_q.status <= nfba_pkg::ST_SMALL;
								end else begin
									count_q <= CW'(1);
									rover_q <= '0;
								end
								state_q <= S_DONE;
							end
							nfba_pkg::REQ_ALLOC: begin
								i_q <= CW'(rover_q);
								state_q <= S_ARD;
							end
							nfba_pkg::REQ_FREE: begin
								i_q <= '0;
								state_q <= (in_data.free_address == 32'd0) ? S_DONE : S_FRD;
								if (in_data.free_address == 32'd0) begin
									rsp_q.status <= nfba_pkg::ST_NULL;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_ARD: begin
					if (i_q >= count_q) begin
						rsp_q.status <= nfba_pkg::ST_NOFIT;
						state_q <= S_DONE;
					end else begin
						state_q <= S_ACHK;
					end
				end
				S_ACHK: begin
					// The first entry examined is the rover entry; keep its used mark.
					if (i_q == CW'(rover_q)) begin
						rov_used_q <= rd_entry.used;
					end
					if (!rd_entry.used && rd_entry.length >= size_q) begin
						hit_q <= i_q[IW-1:0];
						rsp_q.grant_address <= pay;
						if ((rd_entry.length - size_q > HDR) && count_q < MAXC) begin
							split_q <= 1'b1;
							j_q <= count_q;
							state_q <= (count_q > i_q + CW'(1)) ? S_SHRD : S_SPRD;
						end else begin
							split_q <= 1'b0;
							state_q <= S_MARK;
						end
					end else begin
						i_q <= i_q + CW'(1);
						state_q <= S_ARD;
					end
				end
				S_SHRD: state_q <= S_SHWR;
				S_SHWR: begin
					j_q <= j_q - CW'(1);
					state_q <= (j_q - CW'(1) > CW'(hit_q) + CW'(1)) ? S_SHRD : S_SPRD;
				end
				S_SPRD: state_q <= S_SPWR;
				S_SPWR: begin
					count_q <= count_q + CW'(1);
					state_q <= S_MARK;
				end
				S_MARK: begin
					// The rover entry is in use now if it is the granted one or was
					// already in use when the scan passed it.
					if (split_q && (rover_q == hit_q || rov_used_q)) begin
						rover_q <= hit_q + IW'(1);
					end
					state_q <= S_DONE;
				end
				S_FRD: begin
					if (i_q >= count_q) begin
						rsp_q.status <= nfba_pkg::ST_UNKNOWN;
						state_q <= S_DONE;
					end else begin
						state_q <= S_FCHK;
					end
				end
				S_FCHK: begin
					if (pay == addr_q) begin
						hit_q <= i_q[IW-1:0];
						state_q <= S_CLR;
					end else begin
						i_q <= i_q + CW'(1);
						state_q <= S_FRD;
					end
				end
				S_CLR: begin
					fold2_q <= 1'b0;
					if (hit_q != '0) begin
						i_q <= CW'(hit_q) - CW'(1);
						state_q <= S_NBRD;
					end else begin
						i_q <= CW'(1);
						fold2_q <= 1'b1;
						state_q <= (count_q > CW'(1)) ? S_NBRD : S_FLDEND;
					end
				end
				S_NBRD: state_q <= S_NBCHK;
				S_NBCHK: begin
					if (!rd_entry.used) begin
						i_q <= fold2_q ? i_q : i_q + CW'(1);
						state_q <= S_FLDRD;
					end else if (!fold2_q) begin
						fold2_q <= 1'b1;
						i_q <= CW'(hit_q) + CW'(1);
						state_q <= (CW'(hit_q) + CW'(1) < count_q) ? S_NBRD : S_FLDEND;
					end else begin
						state_q <= S_FLDEND;
					end
				end
				S_FLDRD: state_q <= S_FLDLEN;
				S_FLDLEN: begin
					len_q <= rd_entry.length;
					state_q <= S_FLDGRW;
				end
				S_FLDGRW: begin
					j_q <= i_q;
					state_q <= (i_q + CW'(1) < count_q) ? S_FLDSRD : S_FLDEND;
					if (!(i_q + CW'(1) < count_q)) begin
						count_q <= count_q - CW'(1);
						if (CW'(rover_q) >= i_q) rover_q <= rover_q - IW'(1);
					end
				end
				S_FLDSRD: state_q <= S_FLDSWR;
				S_FLDSWR: begin
					j_q <= j_q + CW'(1);
					if (j_q + CW'(2) < count_q) begin
						state_q <= S_FLDSRD;
					end else begin
						count_q <= count_q - CW'(1);
						if (CW'(rover_q) >= i_q) rover_q <= rover_q - IW'(1);
						state_q <= S_FLDEND;
					end
				end
				S_FLDEND: begin
					// After a fold with the lower neighbour the freed block is at k-1.
					if (!fold2_q) begin
						fold2_q <= 1'b1;
						hit_q <= IW'(i_q - CW'(1));
						i_q <= i_q;
						state_q <= (i_q < count_q) ? S_NBRD : S_DONE;
					end else begin
						if (hit_q < rover_q) rover_q <= hit_q;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	property p_count_range;
		@(posedge clk) disable iff (!arst_n) (count_q >= CW'(1)) && (count_q <= MAXC);
	endproperty
	a_count_range: assert property (p_count_range) else $error("block count out of range");

	a_rover_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> CW'(rover_q) < count_q)
		else $error("rover beyond table");

	a_result_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> valid_q) else $error("result not raised");

endmodule

FILE: rtl/core/next_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// next_fit_block_allocator_core
// Next-fit pool allocator with an address-ordered block table.
// ----------------------------------------------------------------------------
// One request is handled at a time, each giving one result. Init rewrites
// the table as one free block; allocate scans the table from the rover and
// shifts the entries above the hit up on a split; free searches from the
// first entry and shifts entries down for each merge. A request is taken
// only once the previous result has been transferred.
module next_fit_block_allocator_core #(
	parameter int MAX_BLOCKS   = nfba_pkg::MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = nfba_pkg::HEADER_BYTES_DEF,
	parameter int POOL_BYTES   = nfba_pkg::POOL_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [31:0]    cfg_wdata,
	input  logic           in_valid,
	output logic           in_stall,
	input  nfba_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output nfba_pkg::rsp_t out_data
);

	localparam int IW = $clog2(MAX_BLOCKS);

	logic [31:0]      pool_base_q;
	nfba_pkg::cmd_t   cmd;
	logic [IW-1:0]    idx;
	nfba_pkg::entry_t rd_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= 32'd0;
		end else if (cfg_we) begin
			pool_base_q <= cfg_wdata;
		end
	end

	nfba_ctrl #(.MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES),
		.POOL_BYTES(POOL_BYTES)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.pool_base(pool_base_q), .cmd(cmd), .idx(idx), .rd_entry(rd_entry)
	);

	nfba_datapath #(.MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES)) u_dp (
		.clk(clk), .cmd(cmd), .idx(idx), .rd_entry(rd_entry)
	);

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next-fit allocator testbench
// Drives init, allocate and free requests with random gaps and stalls, keeps
// its own copy of the block table to predict each grant and status, and
// compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------

class alloc_scoreboard;
	localparam int NBLK = nfba_pkg::MAX_BLOCKS_DEF;
	localparam int HDR  = nfba_pkg::HEADER_BYTES_DEF;

	bit [31:0] base;
	bit [15:0] offs [NBLK];
	bit [15:0] lens [NBLK];
	bit        used [NBLK];
	int        count;
	int        rover;
	nfba_pkg::rsp_t pending [$];
	int        errors;
	bit [31:0] live [$];

	function void setup_pool(bit [15:0] total);
		for (int i = 0; i < NBLK; i++) begin
			offs[i] = 0; lens[i] = 0; used[i] = 0;
		end
		lens[0] = total - HDR;
		count = 1;
		rover = 0;
		live.delete();
	endfunction

	function void reset_state();
		base = 0;
		errors = 0;
		setup_pool(16'(nfba_pkg::POOL_BYTES_DEF));
	endfunction

	function bit [31:0] addr_of(int k);
		return base + 32'(offs[k]) + HDR;
	endfunction

	function void fold(int k);
		lens[k-1] = lens[k-1] + lens[k] + HDR;
		for (int j = k; j + 1 < count; j++) begin
			offs[j] = offs[j+1]; lens[j] = lens[j+1]; used[j] = used[j+1];
		end
		count--;
		if (rover >= k) rover--;
	endfunction

	function void note_request(nfba_pkg::req_t r);
		nfba_pkg::rsp_t e;
		int k;
		bit split;
		e.grant_address = 0;
		e.status = nfba_pkg::ST_OK;
		case (r.req_type)
			nfba_pkg::REQ_INIT: begin
				if (r.request_size < HDR) e.status = nfba_pkg::ST_SMALL;
				else setup_pool(r.request_size);
			end
			nfba_pkg::REQ_ALLOC: begin
				e.status = nfba_pkg::ST_NOFIT;
				for (int i = rover; i < count; i++) begin
					if (used[i] || lens[i] < r.request_size) continue;
					split = 0;
					if (32'(lens[i]) - 32'(r.request_size) > HDR && count < NBLK) begin
						for (int j = count; j > i + 1; j--) begin
							offs[j] = offs[j-1]; lens[j] = lens[j-1]; used[j] = used[j-1];
						end
						offs[i+1] = offs[i] + HDR + r.request_size;
						lens[i+1] = lens[i] - r.request_size - HDR;
						used[i+1] = 0;
						lens[i] = r.request_size;
						count++;
						split = 1;
					end
					used[i] = 1;
					if (split && rover < count && used[rover]) rover = i + 1;
					e.grant_address = addr_of(i);
					e.status = nfba_pkg::ST_OK;
					live.push_back(e.grant_address);
					break;
				end
			end
			nfba_pkg::REQ_FREE: begin
				if (r.free_address == 0) e.status = nfba_pkg::ST_NULL;
				else begin
					k = 0;
					while (k < count && addr_of(k) != r.free_address) k++;
					if (k >= count) e.status = nfba_pkg::ST_UNKNOWN;
					else begin
						used[k] = 0;
						if (k > 0 && !used[k-1]) begin
							fold(k);
							k--;
						end
						if (k + 1 < count && !used[k+1]) fold(k + 1);
						if (k < rover) rover = k;
					end
				end
			end
			default: ;
		endcase
		pending.push_back(e);
	endfunction

	function void check_result(nfba_pkg::rsp_t got);
		nfba_pkg::rsp_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result grant=%h status=%0d",
				$time, got.grant_address, got.status);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (got.grant_address !== e.grant_address) begin
			$display("%0t: grant_address expected %h actual %h",
				$time, e.grant_address, got.grant_address);
			errors++;
		end
		if (got.status !== e.status) begin
			$display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
			errors++;
		end
	endfunction
endclass

module tb;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [31:0] cfg_wdata = 0;
	logic in_valid = 0;
	logic in_stall;
	nfba_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	nfba_pkg::rsp_t out_data;

	alloc_scoreboard sb;
	longint cycles = 0;
	bit hold_off = 0;
	bit sending_done = 0;

	localparam longint CYCLE_LIMIT = 4000000;

	next_fit_block_allocator_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Results are checked at the edge at which the transfer takes place.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_data);
	end

	function int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Receiver stalls, with a long hold-off when asked.
	initial begin
		int n;
		@(negedge clk);
		forever begin
			if (hold_off) begin
				out_stall <= 1;
				repeat (1500) @(negedge clk);
				hold_off = 0;
			end
			n = sending_done ? 0 : gap_len();
			if (n > 0) begin
				out_stall <= 1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 0;
			@(negedge clk);
		end
	end

	// Valid stays high across back-to-back sends; it drops only for a gap or a drain.
	task automatic send(nfba_pkg::req_t r, bit gaps);
		int n;
		n = gaps ? gap_len() : 0;
		if (n > 0) begin
			in_valid <= 0;
			repeat (n) @(negedge clk);
		end
		in_valid <= 1;
		in_data <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(r);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_base(bit [31:0] v);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		sb.base = v;
	endtask

	function nfba_pkg::req_t mk(bit [1:0] t, bit [15:0] s, bit [31:0] a);
		nfba_pkg::req_t r;
		r.req_type = t; r.request_size = s; r.free_address = a;
		return r;
	endfunction

	function nfba_pkg::req_t random_req();
		int p;
		bit [15:0] s;
		p = $urandom_range(0, 99);
		if ($urandom_range(0, 9) < 8) s = 16'($urandom_range(0, 1500));
		else s = 16'($urandom());
		if (p < 2) return mk(nfba_pkg::REQ_INIT,
			$urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 40))
			: 16'($urandom_range(4000, 65535)), $urandom());
		if (p < 48) return mk(nfba_pkg::REQ_ALLOC, s, $urandom());
		if (p < 88 && sb.live.size() != 0)
			return mk(nfba_pkg::REQ_FREE, 16'($urandom()),
				sb.live[$urandom_range(0, sb.live.size() - 1)]);
		if (p < 92) return mk(nfba_pkg::REQ_FREE, s, 32'h0);
		if (p < 97) return mk(nfba_pkg::REQ_FREE, s, $urandom());
		return mk(nfba_pkg::REQ_NOP, s, $urandom());
	endfunction

	initial begin
		bit [31:0] bases [4];
		sb = new();
		sb.reset_state();
		bases = '{32'h0, 32'hFFFF_FFF0, 32'h8000_1234, 32'hFFFF_FFFF};
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed part on the reset pool.
		send(mk(nfba_pkg::REQ_NOP, 16'hFFFF, 32'hFFFF_FFFF), 0);
		send(mk(nfba_pkg::REQ_FREE, 16'd0, 32'h0), 0);
		send(mk(nfba_pkg::REQ_FREE, 16'd0, 32'h1234_5678), 0);
		send(mk(nfba_pkg::REQ_INIT, 16'd15, 32'h0), 0);
		send(mk(nfba_pkg::REQ_INIT, 16'd16, 32'h0), 0);
		send(mk(nfba_pkg::REQ_ALLOC, 16'd0, 32'h0), 0);
		send(mk(nfba_pkg::REQ_ALLOC, 16'd1, 32'h0), 0);
		send(mk(nfba_pkg::REQ_INIT, 16'hFFFF, 32'h0), 0);
		send(mk(nfba_pkg::REQ_ALLOC, 16'hFFFF, 32'h0), 0);
		send(mk(nfba_pkg::REQ_ALLOC, 16'd0, 32'h0), 0);
		send(mk(nfba_pkg::REQ_ALLOC, 16'd100, 32'h0), 0);
		send(mk(nfba_pkg::REQ_ALLOC, 16'd100, 32'h0), 0);
		send(mk(nfba_pkg::REQ_FREE, 16'd0, 32'd16), 0);
		send(mk(nfba_pkg::REQ_FREE, 16'd0, 32'd16), 0);
		send(mk(nfba_pkg::REQ_FREE, 16'd0, 32'd32), 0);
		send(mk(nfba_pkg::REQ_ALLOC, 16'd50, 32'h0), 0);
		// Fill the table until splits are refused.
		for (int i = 0; i < 70; i++) send(mk(nfba_pkg::REQ_ALLOC, 16'd8, 32'h0), 0);
		send(mk(nfba_pkg::REQ_ALLOC, 16'd40000, 32'h0), 0);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			write_base(bases[ph]);
			send(mk(nfba_pkg::REQ_INIT, 16'hFFFF, 32'h0), 1);
			if (ph == 1) hold_off = 1;
			for (int i = 0; i < 500; i++) send(random_req(), 1);
			drain();
		end
		write_base($urandom());
		for (int i = 0; i < 100; i++) send(random_req(), 1);
		sending_done = 1;
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

FILE: files.f
rtl/core/nfba_pkg.sv
rtl/core/nfba_datapath.sv
rtl/core/nfba_ctrl.sv
rtl/core/next_fit_block_allocator_core.sv
bench/tb.sv
